// ===== hdl/bdlp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce package
// Shared types, phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bdlp_pkg;

    localparam int unsigned CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_MS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD_MS   = 8'd1;

    localparam logic [15:0] SETTLE_MS_RESET = 16'd40;
    localparam logic [15:0] HOLD_MS_RESET   = 16'd5000;

    localparam logic [1:0] PH_RELEASED = 2'd0;
    localparam logic [1:0] PH_FALLING  = 2'd1;
    localparam logic [1:0] PH_HELD     = 2'd2;
    localparam logic [1:0] PH_RISING   = 2'd3;

    typedef struct packed {
        logic        level_pressed;
        logic [31:0] now_ms;
        logic        ack_short;
        logic        ack_long;
    } item_t;

    typedef struct packed {
        logic       short_press;
        logic       long_press;
        logic [1:0] debounced_phase;
    } result_t;

endpackage

// ===== hdl/bdlp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce channel interfaces
// Poll channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface bdlp_item_if;
    logic        valid;
    logic        ready;
    logic        level_pressed;
    logic [31:0] now_ms;
    logic        ack_short;
    logic        ack_long;

    modport source (output valid, output level_pressed, output now_ms,
                    output ack_short, output ack_long, input ready);
    modport sink   (input valid, input level_pressed, input now_ms,
                    input ack_short, input ack_long, output ready);
endinterface

interface bdlp_result_if;
    logic       valid;
    logic       ready;
    logic       short_press;
    logic       long_press;
    logic [1:0] debounced_phase;

    modport source (output valid, output short_press, output long_press,
                    output debounced_phase, input ready);
    modport sink   (input valid, input short_press, input long_press,
                    input debounced_phase, output ready);
endinterface

interface bdlp_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/bdlp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce input register
// Captures one poll transaction and holds it until the update stage takes it.
// ----------------------------------------------------------------------------
module bdlp_in_reg
    import bdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bdlp_item_if.sink      item,
    input  logic           advance,
    output logic           valid,
    output item_t          data
);

    logic  valid_reg;
    logic  valid_next;
    item_t data_reg;
    logic  load;

    assign item.ready = !valid_reg || advance;
    assign load       = item.valid && item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= '{level_pressed: item.level_pressed, now_ms: item.now_ms,
                          ack_short: item.ack_short, ack_long: item.ack_long};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ===== hdl/bdlp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce update logic
// Phase machine, debounce and hold timers, press flags and register file.
// ----------------------------------------------------------------------------
module bdlp_core
    import bdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bdlp_cfg_if.sink       cfg,
    input  logic           advance,
    input  item_t          data,
    output result_t        result
);

    logic [15:0] settle_ms_reg;
    logic [15:0] hold_ms_reg;

    logic [1:0]  phase_reg,      phase_next;
    logic        short_reg,      short_next;
    logic        long_reg,       long_next;
    logic [31:0] dbc_start_reg,  dbc_start_next;
    logic        dbc_run_reg,    dbc_run_next;
    logic [31:0] hold_start_reg, hold_start_next;
    logic        hold_run_reg,   hold_run_next;

    logic        short_upd;
    logic        long_upd;
    logic [31:0] dbc_diff;
    logic [31:0] hold_diff;
    logic        dbc_due;
    logic        hold_due;
    logic        dbc_elapsed;
    logic        hold_elapsed;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_ms_reg <= SETTLE_MS_RESET;
            hold_ms_reg   <= HOLD_MS_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_SETTLE_MS)
            begin
                settle_ms_reg <= cfg.data;
            end
            if (cfg.index == CFG_HOLD_MS)
            begin
                hold_ms_reg <= cfg.data;
            end
        end
    end

    assign dbc_diff  = data.now_ms - dbc_start_reg;
    assign hold_diff = data.now_ms - hold_start_reg;
    assign dbc_due   = dbc_diff  >= {16'd0, settle_ms_reg};
    assign hold_due  = hold_diff >= {16'd0, hold_ms_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        short_upd       = short_reg;
        long_upd        = long_reg;
        dbc_start_next  = dbc_start_reg;
        dbc_run_next    = dbc_run_reg;
        hold_start_next = hold_start_reg;
        hold_run_next   = hold_run_reg;
        dbc_elapsed     = 1'b0;
        hold_elapsed    = 1'b0;

        unique case (phase_reg)
            PH_RELEASED:
            begin
                if (data.level_pressed)
                begin
                    phase_next   = PH_FALLING;
                    dbc_run_next = 1'b0;
                end
            end
            PH_FALLING:
            begin
                if (!dbc_run_reg)
                begin
                    dbc_start_next = data.now_ms;
                    dbc_run_next   = 1'b1;
                end
                else if (dbc_due)
                begin
                    dbc_run_next = 1'b0;
                    dbc_elapsed  = 1'b1;
                end
                if (dbc_elapsed)
                begin
                    if (data.level_pressed)
                    begin
                        phase_next    = PH_HELD;
                        hold_run_next = 1'b0;
                        long_upd      = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_RELEASED;
                    end
                end
            end
            PH_HELD:
            begin
                if (!hold_run_reg)
                begin
                    hold_start_next = data.now_ms;
                    hold_run_next   = 1'b1;
                end
                else if (hold_due)
                begin
                    hold_run_next = 1'b0;
                    hold_elapsed  = 1'b1;
                end
                if (hold_elapsed)
                begin
                    long_upd = 1'b1;
                end
                if (!data.level_pressed)
                begin
                    phase_next   = PH_RISING;
                    dbc_run_next = 1'b0;
                end
            end
            PH_RISING:
            begin
                if (!dbc_run_reg)
                begin
                    dbc_start_next = data.now_ms;
                    dbc_run_next   = 1'b1;
                end
                else if (dbc_due)
                begin
                    dbc_run_next = 1'b0;
                    dbc_elapsed  = 1'b1;
                end
                if (dbc_elapsed)
                begin
                    if (!data.level_pressed)
                    begin
                        if (!long_reg)
                        begin
                            short_upd = 1'b1;
                        end
                        phase_next = PH_RELEASED;
                    end
                    else
                    begin
                        phase_next = PH_HELD;
                    end
                end
            end
            default:
            begin
                phase_next = PH_RELEASED;
            end
        endcase

        short_next = short_upd && !data.ack_short;
        long_next  = long_upd  && !data.ack_long;
    end

    assign result = '{short_press: short_upd, long_press: long_upd,
                      debounced_phase: phase_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_RELEASED;
            short_reg      <= 1'b0;
            long_reg       <= 1'b0;
            dbc_start_reg  <= 32'd0;
            dbc_run_reg    <= 1'b0;
            hold_start_reg <= 32'd0;
            hold_run_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            short_reg      <= short_next;
            long_reg       <= long_next;
            dbc_start_reg  <= dbc_start_next;
            dbc_run_reg    <= dbc_run_next;
            hold_start_reg <= hold_start_next;
            hold_run_reg   <= hold_run_next;
        end
    end

    a_released_exit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_RELEASED
        |=> phase_reg == PH_RELEASED || phase_reg == PH_FALLING)
        else $error("released phase left other than to falling");

    a_press_clears_long: assert property (@(posedge clk) disable iff (!rst_n)
        advance && phase_reg == PH_FALLING && phase_next == PH_HELD
        |=> !long_reg && !hold_run_reg)
        else $error("new press did not clear long flag and hold timer");

    a_short_source: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !short_reg && short_upd
        |-> phase_reg == PH_RISING && phase_next == PH_RELEASED && !long_reg)
        else $error("short flag raised outside a clean release");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !advance
        |=> $stable(phase_reg) && $stable(short_reg) && $stable(long_reg))
        else $error("state changed without a transaction");

endmodule

// ===== hdl/bdlp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce result register
// Holds one result transaction until the downstream side takes it.
// ----------------------------------------------------------------------------
module bdlp_out_reg
    import bdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  result_t        data,
    output logic           space,
    bdlp_result_if.source  result
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign space = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign result.valid           = valid_reg;
    assign result.short_press     = data_reg.short_press;
    assign result.long_press      = data_reg.long_press;
    assign result.debounced_phase = data_reg.debounced_phase;

endmodule

// ===== hdl/button_debounce_long_press.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce with short and long press detection
// Debounces polled button levels and reports short and long press flags.
// ----------------------------------------------------------------------------
// Channel   Dir   Payload                                          Handshake
// item      in    level_pressed, now_ms[31:0], ack_short, ack_long valid/ready
// result    out   short_press, long_press, debounced_phase[1:0]    valid/ready
// cfg       in    index[7:0] (0 settle_ms, 1 hold_ms), data[15:0]  valid/ready
//
// One poll per cycle sustained while results are taken; each poll passes the
// input register and then the result register. The phase machine and both
// timer compares are combinational between those two registers.
// Reset restores settle_ms 40, hold_ms 5000 and the released phase.
// A stalled result holds the update stage, and item.ready drops while the
// input register holds a poll. cfg.ready is always high.
// ----------------------------------------------------------------------------
module button_debounce_long_press
    import bdlp_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    bdlp_item_if.sink      item,
    bdlp_result_if.source  result,
    bdlp_cfg_if.sink       cfg
);

    logic    stage_valid;
    item_t   stage_data;
    result_t upd_result;
    logic    out_space;
    logic    advance;

    assign advance = stage_valid && out_space;

    bdlp_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .advance (advance),
        .valid   (stage_valid),
        .data    (stage_data)
    );

    bdlp_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .advance (advance),
        .data    (stage_data),
        .result  (upd_result)
    );

    bdlp_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .data    (upd_result),
        .space   (out_space),
        .result  (result)
    );

endmodule
